FILE: sv/stream_find_and_replace_top_macros.svh
// Assertion macros for the find-and-replace block.
`ifndef STREAM_FIND_AND_REPLACE_TOP_MACROS_SVH
`define STREAM_FIND_AND_REPLACE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define SFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("find-and-replace check failed");
// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define SFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("find-and-replace check failed");
`else
`define SFR_ASSERT_NOW(label, ante, cons)
`define SFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: sv/sfr_pkg.sv
// Shared types, constants and helpers of the find-and-replace block.
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int REG_BYTES = 8;   // bytes held by a pattern or replacement register
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 4;
  localparam int IDX_W     = 3;   // index into a register's bytes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN     = 2'd0,
    REG_PATTERN_LEN = 2'd1,
    REG_REPLACE     = 2'd2,
    REG_REPLACE_LEN = 2'd3
  } cfg_reg_t;

  // Result burst caused by one input transfer, bytes in output order
  typedef struct packed {
    logic [REG_BYTES-1:0][BYTE_W-1:0] data;
    logic [LEN_W-1:0]                 count;
    logic                             last;
  } burst_t;

  // Effective length: zero acts as one, large values saturate at the limit
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len,
                                               input logic [LEN_W-1:0] lim);
    logic [LEN_W-1:0] res;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > lim) begin
      res = lim;
    end else begin
      res = len;
    end
    return res;
  endfunction

endpackage

FILE: sv/sfr_cell.sv
// One window cell: holds a text byte, hands it on, compares the incoming byte.
`timescale 1ns / 1ps
module sfr_cell (
  input  logic                           clk,
  input  logic                           shift_en,
  input  logic [sfr_pkg::BYTE_W-1:0]     d_in,
  input  logic [sfr_pkg::BYTE_W-1:0]     ref_byte,
  output logic [sfr_pkg::BYTE_W-1:0]     q,
  output logic                           hit
);

  logic [sfr_pkg::BYTE_W-1:0] byte_r;

  // compare against what the cell will hold after this transfer
  assign hit = (d_in == ref_byte);
  assign q   = byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d_in;
    end
  end

endmodule

FILE: sv/sfr_burst.sv
// Result serialiser: holds one burst and feeds the registered output stage.
`timescale 1ns / 1ps
module sfr_burst (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sfr_pkg::burst_t             desc_i,
  input  logic                        load_i,
  output logic                        load_ok_o,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sfr_pkg::BYTE_W-1:0]  out_tdata,  // [7:0] out_byte
  output logic                        out_tlast   // out_last
);

  logic [sfr_pkg::REG_BYTES-1:0][sfr_pkg::BYTE_W-1:0] data_r;
  logic [sfr_pkg::LEN_W-1:0]                          cnt_r;
  logic [sfr_pkg::IDX_W-1:0]                          ptr_r;
  logic                                               last_r;
  logic                                               out_valid_r;
  logic [sfr_pkg::BYTE_W-1:0]                         out_data_r;
  logic                                               out_last_r;
  logic                                               busy;
  logic                                               take;
  logic                                               move;

  // a byte moves on whenever the output register is free or being emptied
  assign busy      = (cnt_r != '0);
  assign take      = !out_valid_r || out_tready;
  assign move      = busy && take;
  assign load_ok_o = !busy || (move && (cnt_r == sfr_pkg::LEN_W'(1)));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output stage
      if (move) begin
        out_valid_r <= 1'b1;
        out_data_r  <= data_r[ptr_r];
        out_last_r  <= last_r && (cnt_r == sfr_pkg::LEN_W'(1));
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
      // new burst from an accepted input transfer, else step through the held one
      if (load_i) begin
        data_r <= desc_i.data;
        cnt_r  <= desc_i.count;
        ptr_r  <= '0;
        last_r <= desc_i.last;
      end else if (move) begin
        ptr_r <= ptr_r + sfr_pkg::IDX_W'(1);
        cnt_r <= cnt_r - sfr_pkg::LEN_W'(1);
      end
    end
  end

endmodule

FILE: sv/stream_find_and_replace_top.sv
// Streaming find-and-replace: window cell chain, burst serialiser, config registers.
`timescale 1ns / 1ps
// Replaces every leftmost, non-overlapping occurrence of the pattern in a byte
// stream by the replacement; replaced bytes are never searched again. Bytes
// enter a chain of window cells, one cell per pattern byte, and are compared in
// the cycle of their input transfer. An input transfer is taken every cycle as
// long as the result side keeps up: each transfer yields zero to eight result
// bytes, which a burst register hands out through a registered output stage, one
// per cycle while the receiver keeps up. Input stalls while an earlier burst still
// has bytes to send, unless its last byte moves to the output in that cycle.
// in_tlast flushes the pending window and marks the final result with out_tlast.
// Configuration writes are always accepted; write them between texts (a pattern
// length write drops any pending window bytes).
module stream_find_and_replace_top #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input text
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                            in_tlast,   // end_of_text
  // replaced text
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sfr_pkg::BYTE_W-1:0]      out_tdata,  // [7:0] out_byte
  output logic                            out_tlast,  // out_last
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]       cfg_data
);

`include "stream_find_and_replace_top_macros.svh"

  localparam int PL = (MAX_PATTERN < sfr_pkg::REG_BYTES) ? MAX_PATTERN : sfr_pkg::REG_BYTES;
  localparam int RL = (MAX_REPLACEMENT < sfr_pkg::REG_BYTES) ? MAX_REPLACEMENT
                                                            : sfr_pkg::REG_BYTES;

  // configuration registers
  logic [sfr_pkg::CFG_W-1:0] pattern_r;
  logic [sfr_pkg::LEN_W-1:0] pattern_len_r;
  logic [sfr_pkg::CFG_W-1:0] replace_r;
  logic [sfr_pkg::LEN_W-1:0] replace_len_r;
  logic [sfr_pkg::LEN_W-1:0] fill_r;
  logic [sfr_pkg::LEN_W-1:0] fill_nxt;

  logic                      cfg_fire;
  logic                      in_fire;
  logic                      load_ok;
  logic [sfr_pkg::LEN_W-1:0] plen;
  logic [sfr_pkg::LEN_W-1:0] rlen;
  logic [sfr_pkg::LEN_W-1:0] fill_base;
  logic [sfr_pkg::LEN_W-1:0] fill_new;
  logic                      full;
  logic                      match;
  logic                      found;
  sfr_pkg::burst_t           desc;

  logic [PL-1:0][sfr_pkg::BYTE_W-1:0] cell_d;
  logic [PL-1:0][sfr_pkg::BYTE_W-1:0] cell_q;
  logic [PL-1:0][sfr_pkg::BYTE_W-1:0] cell_ref;
  logic [PL-1:0]                      cell_hit;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_tready = load_ok;
  assign in_fire   = in_tvalid && in_tready;

  assign plen = sfr_pkg::eff_len(pattern_len_r, sfr_pkg::LEN_W'(PL));
  assign rlen = sfr_pkg::eff_len(replace_len_r, sfr_pkg::LEN_W'(RL));

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r     <= '0;
      pattern_len_r <= sfr_pkg::LEN_W'(1);
      replace_r     <= '0;
      replace_len_r <= sfr_pkg::LEN_W'(1);
    end else if (cfg_fire) begin
      case (sfr_pkg::cfg_reg_t'(cfg_index))
        sfr_pkg::REG_PATTERN:     pattern_r     <= cfg_data;
        sfr_pkg::REG_PATTERN_LEN: pattern_len_r <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::REG_REPLACE:     replace_r     <= cfg_data;
        sfr_pkg::REG_REPLACE_LEN: replace_len_r <= cfg_data[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // chain wiring: the newest byte enters cell 0, cell k holds the byte k transfers old
  always_comb begin
    for (int k = 0; k < PL; k++) begin
      cell_d[k]   = (k == 0) ? in_tdata : cell_q[(k == 0) ? 0 : k - 1];
      cell_ref[k] = '0;
      // cell k lines up with pattern byte plen-1-k
      for (int i = 0; i < sfr_pkg::REG_BYTES; i++) begin
        if (5'(i + k + 1) == {1'b0, plen}) begin
          cell_ref[k] = pattern_r[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
        end
      end
    end
  end

  for (genvar g = 0; g < PL; g++) begin : g_cell
    sfr_cell u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .d_in     (cell_d[g]),
      .ref_byte (cell_ref[g]),
      .q        (cell_q[g]),
      .hit      (cell_hit[g])
    );
  end

  // match over the cells in use
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < PL; k++) begin
      if (sfr_pkg::LEN_W'(k) < plen && !cell_hit[k]) begin
        match = 1'b0;
      end
    end
  end

  assign fill_base = (fill_r >= plen) ? '0 : fill_r;
  assign fill_new  = fill_base + sfr_pkg::LEN_W'(1);
  assign full      = (fill_new == plen);
  assign found     = full && match;

  // result burst of this transfer
  always_comb begin
    desc.last = in_tlast;
    desc.data = '0;
    if (found) begin
      desc.count = rlen;
      for (int j = 0; j < sfr_pkg::REG_BYTES; j++) begin
        desc.data[j] = replace_r[j*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
      end
    end else begin
      if (in_tlast) begin
        desc.count = fill_new;
      end else if (full) begin
        desc.count = sfr_pkg::LEN_W'(1);
      end else begin
        desc.count = '0;
      end
      // oldest pending byte first: output byte j comes from cell fill_new-1-j
      for (int j = 0; j < sfr_pkg::REG_BYTES; j++) begin
        for (int k = 0; k < PL; k++) begin
          if (5'(k + j + 1) == {1'b0, fill_new}) begin
            desc.data[j] = cell_d[k];
          end
        end
      end
    end
  end

  // window fill count
  always_comb begin
    if (in_tlast || found) begin
      fill_nxt = '0;
    end else if (full) begin
      fill_nxt = plen - sfr_pkg::LEN_W'(1);
    end else begin
      fill_nxt = fill_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cfg_fire && (sfr_pkg::cfg_reg_t'(cfg_index) == sfr_pkg::REG_PATTERN_LEN)) begin
      fill_r <= '0;
    end else if (in_fire) begin
      fill_r <= fill_nxt;
    end
  end

  sfr_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_i     (desc),
    .load_i     (in_fire),
    .load_ok_o  (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // pending bytes never reach a full pattern between transfers
  `SFR_ASSERT_NOW(a_fill_below_plen, 1'b1, fill_r < plen)
  // the final byte of a text always produces at least one result
  `SFR_ASSERT_NOW(a_last_has_result, in_fire && in_tlast, desc.count != '0)
  // the window is empty after the final byte of a text
  `SFR_ASSERT_NEXT(a_last_clears_fill, in_fire && in_tlast && !cfg_fire, fill_r == '0)

endmodule

FILE: tb/stream_find_and_replace_top_tb.sv
// Self-checking testbench for the streaming find-and-replace block.
`timescale 1ns / 1ps
module stream_find_and_replace_top_tb;

  localparam int LEN_CAP      = 8;   // longest effective pattern or replacement
  localparam int DRAIN_CYCLES = 16;  // quiet cycles before a register write or the end
  localparam int HOLD_CYCLES  = 400; // long receiver hold-off

  // Expected result byte with its end-of-text mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_out_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [7:0]                in_tdata = '0;   // [7:0] data_byte
  logic                      in_tlast = 1'b0; // end_of_text
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [7:0]                out_tdata;       // [7:0] out_byte
  logic                      out_tlast;       // out_last
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  sfr_pkg::cfg_reg_t         cfg_index = sfr_pkg::REG_PATTERN;
  logic [sfr_pkg::CFG_W-1:0] cfg_data = '0;

  // Predictor state: configuration copy and pending window
  logic [63:0] find_word;
  logic [3:0]  find_len;
  logic [63:0] subst_word;
  logic [3:0]  subst_len;
  logic [7:0]  window_bytes [LEN_CAP];
  int          window_count;

  text_out_t   pending_text [$];
  text_out_t   got;
  int          mismatches = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          stall_left = 0;

  stream_find_and_replace_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("stream_find_and_replace_top_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Zero acts as one, anything above the cap saturates
  function automatic int clip_len(input logic [3:0] len);
    if (len == 4'd0) return 1;
    if (len > LEN_CAP) return LEN_CAP;
    return int'(len);
  endfunction

  // Work out the result bytes caused by one accepted input byte
  task automatic replace_step(input logic [7:0] b, input bit last);
    int         plen;
    int         rlen;
    bit         hit;
    logic [7:0] burst [$];
    text_out_t  t;
    plen = clip_len(find_len);
    rlen = clip_len(subst_len);
    if (window_count >= plen) window_count = 0;
    window_bytes[window_count] = b;
    window_count++;
    if (window_count == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (window_bytes[i] != find_word[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < rlen; i++) burst.push_back(subst_word[8*i +: 8]);
        window_count = 0;
      end else begin
        burst.push_back(window_bytes[0]);
        for (int i = 1; i < window_count; i++) window_bytes[i-1] = window_bytes[i];
        window_count--;
      end
    end
    // end of text flushes whatever is still pending
    if (last) begin
      for (int i = 0; i < window_count; i++) burst.push_back(window_bytes[i]);
      window_count = 0;
    end
    for (int i = 0; i < burst.size(); i++) begin
      t.data = burst[i];
      t.last = last && (i == burst.size() - 1);
      pending_text.push_back(t);
    end
  endtask

  // Offer one byte, with random gaps, and record it once transferred
  task automatic send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    replace_step(b, last);
    items_sent++;
  endtask

  // Send a run of bytes; close marks the final one as end of text
  task automatic send_run(input logic [7:0] text [$], input bit close);
    for (int i = 0; i < text.size(); i++)
      send_byte(text[i], close && (i == text.size() - 1));
    in_tvalid <= 1'b0;
  endtask

  // Wait until every expected byte is out and the block has gone quiet
  task automatic settle();
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register transfer; the caller lowers cfg_valid afterwards
  task automatic cfg_transfer(input sfr_pkg::cfg_reg_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sfr_pkg::REG_PATTERN:     find_word = value;
      sfr_pkg::REG_PATTERN_LEN: begin
        find_len     = value[3:0];
        window_count = 0;
      end
      sfr_pkg::REG_REPLACE:     subst_word = value;
      sfr_pkg::REG_REPLACE_LEN: subst_len = value[3:0];
      default: ;
    endcase
  endtask

  task automatic write_one(input sfr_pkg::cfg_reg_t idx, input logic [63:0] value);
    settle();
    cfg_transfer(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(input logic [63:0] pw, input logic [63:0] pl,
                             input logic [63:0] rw, input logic [63:0] rl);
    settle();
    cfg_transfer(sfr_pkg::REG_PATTERN, pw);
    cfg_transfer(sfr_pkg::REG_PATTERN_LEN, pl);
    cfg_transfer(sfr_pkg::REG_REPLACE, rw);
    cfg_transfer(sfr_pkg::REG_REPLACE_LEN, rl);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  = hold_req;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every result transfer with the oldest expected byte
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_text.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_tdata));
      end else begin
        got = pending_text.pop_front();
        if (out_tdata !== got.data)
          report_mismatch($sformatf("out_byte %02h, wanted %02h", out_tdata, got.data));
        if (out_tlast !== got.last)
          report_mismatch($sformatf("out_last %0b, wanted %0b", out_tlast, got.last));
      end
    end
  end

  // Length register value with random upper bits over the given nibble
  function automatic logic [63:0] len_value(input logic [3:0] len);
    logic [63:0] v;
    v      = {$urandom, $urandom};
    v[3:0] = len;
    return v;
  endfunction

  task automatic test_reset_defaults();
    logic [7:0] t [$];
    // after reset a lone zero byte is replaced by a zero byte
    t = '{8'h5A, 8'h00};
    send_run(t, 1'b1);
  endtask

  task automatic test_full_length_match();
    logic [7:0] t [$];
    load_config(64'h0807060504030201, 64'd8, 64'h8899AABBCCDDEEFF, 64'd8);
    t = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h01};
    send_run(t, 1'b1);
  endtask

  task automatic test_length_limits();
    logic [7:0] t [$];
    // zero pattern length acts as one, oversized replacement saturates
    load_config(64'h00000000000000FF, 64'd0, 64'hFF00FF00FF00FF00, 64'd15);
    t = '{8'hFF, 8'h00};
    send_run(t, 1'b1);
    // oversized pattern length, zero replacement length; final byte alone
    load_config(64'hFFFFFFFFFFFFFFFF, 64'd9, 64'h00000000000000FF, 64'd0);
    t = '{8'hFF};
    send_run(t, 1'b1);
  endtask

  task automatic test_self_containing_subst();
    logic [7:0] t [$];
    // "ab" becomes "xaby"; the copy of the pattern is not searched again
    load_config(64'h6261, 64'd2, 64'h79626178, 64'd4);
    t = '{8'h61, 8'h61, 8'h62, 8'h61, 8'h62};
    send_run(t, 1'b1);
  endtask

  task automatic test_mid_text_writes();
    logic [7:0] t [$];
    load_config(64'h636261, 64'd3, 64'h5A, 64'd1);
    t = '{8'h61, 8'h62};
    send_run(t, 1'b0);
    // replacement change applies to the match completed next
    write_one(sfr_pkg::REG_REPLACE, 64'h51);
    t = '{8'h63};
    send_run(t, 1'b0);
    t = '{8'h61, 8'h62};
    send_run(t, 1'b0);
    // pattern length write drops the pending window
    write_one(sfr_pkg::REG_PATTERN_LEN, 64'd3);
    t = '{8'h63, 8'h64};
    send_run(t, 1'b1);
  endtask

  // New random configuration; small alphabet half the time so matches occur
  task automatic random_config();
    logic [63:0] pw;
    logic [63:0] rw;
    logic [3:0]  pl;
    logic [3:0]  rl;
    bit          alpha;
    alpha = $urandom_range(1);
    pw = {$urandom, $urandom};
    rw = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      if (alpha) pw[8*i +: 8] = 8'h61 + 8'($urandom_range(1));
      if ($urandom_range(1)) rw[8*i +: 8] = 8'h61 + 8'($urandom_range(1));
    end
    pl = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9)))
                                  : 4'($urandom_range(8, 1));
    rl = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9)))
                                  : 4'($urandom_range(8, 1));
    load_config(pw, len_value(pl), rw, len_value(rl));
  endtask

  // Texts built mostly from whole and broken copies of the pattern
  task automatic test_random_texts(input int goal);
    logic [7:0] t [$];
    int         target;
    int         plen;
    int         cut;
    int         pick;
    goal = items_sent + goal;
    while (items_sent < goal) begin
      random_config();
      plen   = clip_len(find_len);
      target = $urandom_range(12, 1);
      t.delete();
      while (t.size() < target) begin
        pick = $urandom_range(9);
        if (pick <= 5) begin
          cut = (pick <= 3) ? plen : $urandom_range(plen);
          for (int i = 0; i < cut; i++) t.push_back(find_word[8*i +: 8]);
        end else if (pick <= 7) begin
          t.push_back(8'h61 + 8'($urandom_range(1)));
        end else begin
          t.push_back(8'($urandom_range(255)));
        end
      end
      send_run(t, 1'b1);
    end
  endtask

  // Bytes equal to the pattern expand eightfold while the receiver holds off
  task automatic test_backpressure();
    logic [7:0] t [$];
    load_config(64'h61, 64'd1, {$urandom, $urandom}, 64'd8);
    hold_req <= hold_req + 1;
    for (int i = 0; i < 24; i++)
      t.push_back(($urandom_range(3) != 0) ? 8'h61 : 8'($urandom_range(255)));
    send_run(t, 1'b1);
  endtask

  initial begin
    find_word    = '0;
    find_len     = 4'd1;
    subst_word   = '0;
    subst_len    = 4'd1;
    window_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 68;
    test_reset_defaults();
    test_full_length_match();
    test_length_limits();
    test_self_containing_subst();
    test_mid_text_writes();
    test_random_texts(25);

    send_idle_pct = 68;
    recv_idle_pct = 20;
    test_random_texts(25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_texts(25);

    settle();
    if (mismatches == 0) begin
      $display("stream_find_and_replace_top_tb passed");
    end else begin
      $display("stream_find_and_replace_top_tb failed");
    end
    $finish;
  end

endmodule
